// ===== design/msort_pkg.sv =====
`default_nettype none

package msort_pkg;

   // Element format: signed Q8.8
   localparam int VALUE_W = 16;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // input transfer this cycle
      logic pass_init;   // start the first exchange pass
      logic scan_issue;  // issue a store read for the scan
      logic wrback;      // write the held minimum back, advance the pass
      logic emit_init;   // start result emission at entry zero
      logic emit_issue;  // issue a store read for the next result
      logic emit_load;   // load the result register
      logic emit_next;   // advance the result index
      logic set_clear;   // set done: clear count and overflow
   } msort_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic few;         // fewer than two elements stored
      logic scan_last;   // scan read is at the last stored entry
      logic pass_last;   // current pass is the final one
      logic out_taken;   // result transfer this cycle
      logic out_last;    // held result is the final one of the set
   } msort_status_type;

endpackage

`default_nettype wire

// ===== design/msort_req_if.sv =====
`default_nettype none

interface msort_req_if;
   logic                 valid;
   logic                 ready;
   msort_pkg::value_type value;
   logic                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== design/msort_rsp_if.sv =====
`default_nettype none

interface msort_rsp_if;
   logic                 valid;
   logic                 ready;
   msort_pkg::value_type value_res;
   logic                 last_out;
   logic                 overflow;

   modport source (output valid, output value_res, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input value_res, input last_out, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== design/msort_ctrl.sv =====
`default_nettype none

module msort_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last,
   output logic                         req_ready,
   output msort_pkg::msort_cmd_type     cmd,
   input  wire msort_pkg::msort_status_type st
);
   import msort_pkg::*;

   localparam logic [2:0] S_LOAD      = 3'd0;
   localparam logic [2:0] S_START     = 3'd1;
   localparam logic [2:0] S_SCAN      = 3'd2;
   localparam logic [2:0] S_DRAIN     = 3'd3;
   localparam logic [2:0] S_WRBACK    = 3'd4;
   localparam logic [2:0] S_EMIT_RD   = 3'd5;
   localparam logic [2:0] S_EMIT_LD   = 3'd6;
   localparam logic [2:0] S_EMIT_WAIT = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (st.few) begin
               cmd.emit_init = 1'b1;
               state_in      = S_EMIT_RD;
            end else begin
               cmd.pass_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (st.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_WRBACK;
         end
         S_WRBACK: begin
            cmd.wrback = 1'b1;
            if (st.pass_last) begin
               cmd.emit_init = 1'b1;
               state_in      = S_EMIT_RD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_issue = 1'b1;
            state_in       = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (st.out_taken) begin
               if (st.out_last) begin
                  cmd.set_clear = 1'b1;
                  state_in      = S_LOAD;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // Inputs are only taken while loading
   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_LOAD)
      else $error("ready outside load");

   // A last element always moves on to the sort start
   a_last_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> state_ff == S_START)
      else $error("last element did not start sort");

   // A drain cycle always follows the final scan read
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && st.scan_last) |=> state_ff == S_DRAIN)
      else $error("scan did not drain");
`endif

endmodule

`default_nettype wire

// ===== design/msort_dp.sv =====
`default_nettype none

module msort_dp #(
   parameter int MAX_ELEMS = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire msort_pkg::value_type       req_value,
   input  wire msort_pkg::msort_cmd_type   cmd,
   output msort_pkg::msort_status_type     st,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output msort_pkg::value_type            rsp_value_res,
   output logic                            rsp_last_out,
   output logic                            rsp_overflow
);
   import msort_pkg::*;

   localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ELEMS + 1);

   function automatic logic is_pos(input value_type v);
      is_pos = (v != '0) && !v[VALUE_W-1];
   endfunction

   value_type store_mem [MAX_ELEMS];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   value_type         cur_ff, cur_in;
   value_type         rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] cmp_addr_ff;
   logic              cmp_valid_ff;
   logic              cmp_first_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff;
   logic              rsp_last_ff;
   logic              rsp_ovf_ff;

   logic              full;
   logic              swap;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   value_type         mem_wdata;
   logic [CNT_W-1:0]  count_m1;

   assign full     = (count_ff == CNT_W'(MAX_ELEMS));
   assign count_m1 = count_ff - CNT_W'(1);

   // Compare stage: swap when the read entry is a smaller positive than the held one
   assign swap = cmp_valid_ff && !cmp_first_ff && is_pos(cur_ff) && is_pos(rd_data_ff)
                 && (rd_data_ff < cur_ff);

   // Store write port: load, swap, or pass writeback (never two at once)
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = req_value;
      if (cmd.load && !full) begin
         mem_we = 1'b1;
      end else if (swap) begin
         mem_we    = 1'b1;
         mem_waddr = cmp_addr_ff;
         mem_wdata = cur_ff;
      end else if (cmd.wrback) begin
         mem_we    = 1'b1;
         mem_waddr = i_ff;
         mem_wdata = cur_ff;
      end
   end

   assign rd_addr = cmd.emit_issue ? k_ff : j_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Counters and held minimum
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.set_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
      if (cmd.pass_init) begin
         i_in = '0;
         j_in = '0;
      end
      if (cmd.scan_issue) begin
         j_in = j_ff + ADDR_W'(1);
      end
      if (cmd.wrback) begin
         i_in = i_ff + ADDR_W'(1);
         j_in = i_ff + ADDR_W'(1);
      end
      if (cmd.emit_init) begin
         k_in = '0;
      end
      if (cmd.emit_next) begin
         k_in = k_ff + ADDR_W'(1);
      end
      if (cmp_valid_ff && (cmp_first_ff || swap)) begin
         cur_in = rd_data_ff;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         cmp_valid_ff <= cmd.scan_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      cmp_addr_ff  <= j_ff;
      cmp_first_ff <= (j_ff == i_ff);
      if (cmd.emit_load) begin
         rsp_value_ff <= rd_data_ff;
         rsp_last_ff  <= (CNT_W'(k_ff) == count_m1);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // Status
   assign st.few       = (count_ff < CNT_W'(2));
   assign st.scan_last = (CNT_W'(j_ff) == count_m1);
   assign st.pass_last = ((CNT_W'(i_ff) + CNT_W'(2)) >= count_ff);
   assign st.out_taken = rsp_valid_ff && rsp_ready;
   assign st.out_last  = rsp_last_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

`ifndef ASSERT_OFF
   // Stored count never passes the store depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMS))
      else $error("element count beyond depth");

   // No input transfer while a result is pending
   a_no_load_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && rsp_valid_ff))
      else $error("load while result pending");

   // Swap writes and pass writebacks never meet on the write port
   a_wr_conflict: assert property (@(posedge clock) disable iff (reset)
      !(swap && (cmd.wrback || cmd.load)))
      else $error("store write port conflict");

   // An overflowed set always filled the store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow without full store");
`endif

endmodule

`default_nettype wire

// ===== design/masked_positive_sort.sv =====
// Loads a set of signed Q8.8 elements, one per transfer, up to the one marked last, then
// sorts the strictly positive elements into ascending order in the positions that held
// positives; zero and negative elements stay put. The whole set is then returned in
// position order, last_out on the final result. Elements past MAX_ELEMS are dropped and
// overflow is raised on every result of that set. Inputs are accepted only while loading,
// not during the sort or the result emission. Sets of two or more elements are sorted in
// exchange passes, bound by the single read and single write port of the element store:
// one compare per cycle in an exchange pass, plus a drain and a writeback state per pass.
// Each result is then read from the store, loaded into the result register and held
// until taken; the next result is read only after that.
`default_nettype none

module masked_positive_sort #(
   parameter int MAX_ELEMS = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   msort_req_if.sink   req_chan,
   msort_rsp_if.source rsp_chan
);
   import msort_pkg::*;

   msort_cmd_type    cmd;
   msort_status_type st;
   logic             req_ready;
   logic             rsp_valid;
   value_type        rsp_value_res;
   logic             rsp_last_out;
   logic             rsp_overflow;

   msort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   msort_dp #(
      .MAX_ELEMS (MAX_ELEMS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_chan.value),
      .cmd           (cmd),
      .st            (st),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last_out  (rsp_last_out),
      .rsp_overflow  (rsp_overflow)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.value_res = rsp_value_res;
   assign rsp_chan.last_out  = rsp_last_out;
   assign rsp_chan.overflow  = rsp_overflow;

endmodule

`default_nettype wire

// ===== verif/msort_checker.sv =====
`timescale 1ns / 1ps

module msort_checker #(
   parameter int DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   msort_req_if      req_mon,
   msort_rsp_if      rsp_mon,
   output int        mismatch_count,
   output int        results_owed
);
   import msort_pkg::*;

   typedef struct packed {
      value_type value_res;
      logic      last_out;
      logic      overflow;
   } sorted_elem_type;

   // Shadow of the element store and set bookkeeping
   value_type       elem_store [DEPTH];
   int              elem_count;
   logic            elem_dropped;
   sorted_elem_type sorted_q [$];
   int              errors = 0;
   int              result_index = 0;

   assign mismatch_count = errors;

   initial results_owed = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   always @(posedge clock) begin
      sorted_elem_type want;
      value_type       positives [DEPTH];
      value_type       held;
      int              num_pos;
      int              k;
      int              j;
      if (reset) begin
         elem_count   = 0;
         elem_dropped = 1'b0;
      end else begin
         // Result transfer: compare with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (sorted_q.size() == 0) begin
               report_mismatch($sformatf("result %0d (value %0d) with nothing expected",
                                         result_index, rsp_mon.value_res));
            end else begin
               want = sorted_q.pop_front();
               if (rsp_mon.value_res !== want.value_res)
                  report_mismatch($sformatf("result %0d: value_res %0d, expected %0d",
                                            result_index, rsp_mon.value_res, want.value_res));
               if (rsp_mon.last_out !== want.last_out)
                  report_mismatch($sformatf("result %0d: last_out %b, expected %b",
                                            result_index, rsp_mon.last_out, want.last_out));
               if (rsp_mon.overflow !== want.overflow)
                  report_mismatch($sformatf("result %0d: overflow %b, expected %b",
                                            result_index, rsp_mon.overflow, want.overflow));
            end
            result_index++;
         end

         // Input transfer: store or drop, and on the last one predict the sorted set
         if (req_mon.valid && req_mon.ready) begin
            if (elem_count < DEPTH) begin
               elem_store[elem_count] = req_mon.value;
               elem_count++;
            end else begin
               elem_dropped = 1'b1;
            end

            if (req_mon.last) begin
               // gather strictly positive elements
               num_pos = 0;
               for (k = 0; k < elem_count; k++) begin
                  if (elem_store[k] > 0) begin
                     positives[num_pos] = elem_store[k];
                     num_pos++;
                  end
               end
               // ascending insertion sort
               for (k = 1; k < num_pos; k++) begin
                  held = positives[k];
                  j    = k - 1;
                  while (j >= 0 && positives[j] > held) begin
                     positives[j+1] = positives[j];
                     j--;
                  end
                  positives[j+1] = held;
               end
               // put them back into the positive slots, zero/negative stay put
               num_pos = 0;
               for (k = 0; k < elem_count; k++) begin
                  if (elem_store[k] > 0) begin
                     want.value_res = positives[num_pos];
                     num_pos++;
                  end else begin
                     want.value_res = elem_store[k];
                  end
                  want.last_out = (k == elem_count - 1);
                  want.overflow = elem_dropped;
                  sorted_q.push_back(want);
               end
               elem_count   = 0;
               elem_dropped = 1'b0;
            end
         end
      end
      results_owed <= sorted_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import msort_pkg::*;

   localparam int ELEM_DEPTH    = 64;
   localparam int STALL_LIMIT   = 12000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int DIRECTED_LEN  = 21;

   // {last, value}: single element, mixed extremes, no positives, descending run
   localparam logic [16:0] DIRECTED_SETS [DIRECTED_LEN] = '{
      17'h1_7FFF,
      17'h0_0100, 17'h0_FFFF, 17'h0_7FFF, 17'h0_0000, 17'h0_0001, 17'h0_8000,
      17'h0_0100, 17'h0_0001, 17'h0_0080, 17'h0_0000, 17'h1_7FFE,
      17'h0_FF00, 17'h0_0000, 17'h0_8000, 17'h1_0000,
      17'h0_0005, 17'h0_0004, 17'h0_0003, 17'h0_0002, 17'h1_0001
   };

   logic clock = 1'b0;
   logic reset;

   msort_req_if req_chan ();
   msort_rsp_if rsp_chan ();

   int mismatch_count;
   int results_owed;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left = 0;
   int elems_sent = 0;
   int quiet_cycles = 0;

   masked_positive_sort #(
      .MAX_ELEMS (ELEM_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msort_checker #(
      .DEPTH (ELEM_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Random element: full range, small positives for duplicates, zero and extremes
   function automatic value_type rand_elem();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40)
         return value_type'($urandom);
      else if (pick < 60)
         return value_type'($urandom_range(16, 1));
      else if (pick < 75)
         return '0;
      else if (pick < 90)
         case ($urandom_range(3))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0001;
            default: return 16'shFFFF;
         endcase
      else
         return value_type'(16'h8000 | $urandom_range(16'h7FFF));
   endfunction

   // Mostly short sets, a few medium, rarely near-full, full or overflowing
   function automatic int rand_set_len();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return $urandom_range(12, 1);
      else if (pick < 97)
         return $urandom_range(40, 13);
      else
         return $urandom_range(70, 60);
   endfunction

   // One input transfer, with random idle cycles ahead of it
   task automatic send_elem(input value_type val, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= val;
      req_chan.last  <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      elems_sent++;
   endtask

   task automatic send_set(input int len);
      int k;
      for (k = 0; k < len; k++)
         send_elem(rand_elem(), k == len - 1);
   endtask

   task automatic wait_all_results();
      @(posedge clock);
      wait (results_owed == 0);
   endtask

   // Result side: random back-pressure, or a long hold-off when requested
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Stimulus
   initial begin
      int k;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.last  = 1'b0;
      send_idle_pct  = 31;
      recv_idle_pct  = 69;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_LEN; k++)
         send_elem(value_type'(DIRECTED_SETS[k][15:0]), DIRECTED_SETS[k][16]);
      while (elems_sent < 150)
         send_set(rand_set_len());

      // swap idling, include a full set and one that drops its last element
      send_idle_pct = 69;
      recv_idle_pct = 31;
      send_set(ELEM_DEPTH);
      send_set(ELEM_DEPTH + 1);
      while (elems_sent < 300)
         send_set(rand_set_len());

      // receiver holds off while the next set is offered
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = HOLD_CYCLES;
      send_set(12);
      send_set(9);

      // sender pauses until the block has drained
      req_chan.valid <= 1'b0;
      wait_all_results();

      send_set(ELEM_DEPTH + 6);
      while (elems_sent < 460)
         send_set(rand_set_len());
      req_chan.valid <= 1'b0;

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog: too long without any transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

// ===== masked_positive_sort.f =====
design/msort_pkg.sv
design/msort_req_if.sv
design/msort_rsp_if.sv
design/msort_ctrl.sv
design/msort_dp.sv
design/masked_positive_sort.sv
verif/msort_checker.sv
verif/testbench.sv
